// ===== sv/gccs_pkg.sv =====
// Shared types, constants and helper functions of the grid cell contour block.
// Used by gccs_xunit and grid_cell_contour_segments_unit; depends on nothing.
package gccs_pkg;

    // Internal widths: scaled height differences, their distance, level accumulator.
    localparam int H_W = 36;
    localparam int D_W = H_W + 1;
    localparam int L_W = 38;
    localparam int C_W = 32;
    localparam int N_W = H_W + C_W;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_STEP  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // Sign codes of a vertex height relative to the level.
    localparam logic [1:0] SGN_NEG  = 2'd0;
    localparam logic [1:0] SGN_ZERO = 2'd1;
    localparam logic [1:0] SGN_POS  = 2'd2;

    // Segment kinds of one triangle; X marks a crossing on an edge.
    typedef enum logic [3:0] {
        SEG_NONE, SEG_A_B, SEG_B_C, SEG_C_A, SEG_A_XBC, SEG_B_XCA,
        SEG_C_XAB, SEG_XAB_XBC, SEG_XBC_XCA, SEG_XCA_XAB
    } t_case;

    // Source of one segment end: a vertex or an edge crossing.
    typedef enum logic [2:0] {SRC_A, SRC_B, SRC_C, SRC_AB, SRC_BC, SRC_CA} t_src;

    typedef struct packed {
        t_src s;
        t_src e;
    } t_route;

    // Case table, indexed by sign(a)*9 + sign(centre)*3 + sign(c).
    localparam t_case CASE_TBL [27] = '{
        SEG_NONE,    SEG_NONE,  SEG_XBC_XCA,
        SEG_NONE,    SEG_B_C,   SEG_B_XCA,
        SEG_XAB_XBC, SEG_C_XAB, SEG_XCA_XAB,
        SEG_NONE,    SEG_C_A,   SEG_A_XBC,
        SEG_A_B,     SEG_C_A,   SEG_A_B,
        SEG_A_XBC,   SEG_C_A,   SEG_NONE,
        SEG_XCA_XAB, SEG_C_XAB, SEG_XAB_XBC,
        SEG_B_XCA,   SEG_B_C,   SEG_NONE,
        SEG_XBC_XCA, SEG_NONE,  SEG_NONE
    };

    // Top level sequencer states.
    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_LEVEL, S_HCALC, S_TRI, S_COORD, S_WAIT, S_SEG, S_FIN
    } t_state;

    // Crossing unit states.
    typedef enum logic [1:0] {X_IDLE, X_MUL, X_DIV, X_DONE} t_xstate;

    // Request to the crossing unit.
    typedef struct packed {
        logic                  start;
        logic signed [H_W-1:0] ha;
        logic signed [H_W-1:0] hb;
        logic signed [C_W-1:0] ca;
        logic signed [C_W-1:0] cb;
    } t_xreq;

    // Status of the crossing unit.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic signed [C_W-1:0] result;
    } t_xrsp;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic load_item;
        logic setup;
        logic lvl_next;
        logic h_load;
        logic tri_next;
        logic route_load;
        logic cur_vert;
        logic cur_div;
        logic j_next;
        logic x_start;
        logic pend_load;
        logic out_load;
        logic out_last;
        logic pend_clear;
    } t_ctl;

    function automatic logic [1:0] sign_idx(input logic signed [H_W-1:0] h);
        logic [1:0] r;
        if (h == '0) begin
            r = SGN_ZERO;
        end else if (h[H_W-1]) begin
            r = SGN_NEG;
        end else begin
            r = SGN_POS;
        end
        return r;
    endfunction

    function automatic t_case case_code(input logic [1:0] sa, input logic [1:0] sb,
                                        input logic [1:0] sc);
        logic [4:0] idx;
        idx = 5'(sa) * 5'd9 + 5'(sb) * 5'd3 + 5'(sc);
        return CASE_TBL[idx];
    endfunction

    function automatic t_route case_route(input t_case c);
        t_route r;
        unique case (c)
            SEG_A_B:     r = '{s: SRC_A,  e: SRC_B};
            SEG_B_C:     r = '{s: SRC_B,  e: SRC_C};
            SEG_C_A:     r = '{s: SRC_C,  e: SRC_A};
            SEG_A_XBC:   r = '{s: SRC_A,  e: SRC_BC};
            SEG_B_XCA:   r = '{s: SRC_B,  e: SRC_CA};
            SEG_C_XAB:   r = '{s: SRC_C,  e: SRC_AB};
            SEG_XAB_XBC: r = '{s: SRC_AB, e: SRC_BC};
            SEG_XBC_XCA: r = '{s: SRC_BC, e: SRC_CA};
            SEG_XCA_XAB: r = '{s: SRC_CA, e: SRC_AB};
            default:     r = '{s: SRC_A,  e: SRC_A};
        endcase
        return r;
    endfunction

endpackage

// ===== sv/gccs_xunit.sv =====
// Serial edge crossing unit: ca + ha*(cb-ca)/(ha-hb), truncated toward ca.
// Shift-add multiply, then restoring divide, one bit per cycle. Uses gccs_pkg.
module gccs_xunit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gccs_pkg::t_xreq i_req,
    output gccs_pkg::t_xrsp o_rsp
);
    import gccs_pkg::*;

    t_xstate               r_state, n_state;
    logic [D_W-1:0]        r_d;
    logic [H_W-1:0]        r_ma;
    logic [C_W-1:0]        r_mdc;
    logic [C_W-1:0]        r_nlo;
    logic [N_W-1:0]        r_acc;
    logic [D_W-1:0]        r_rem;
    logic [4:0]            r_cnt;
    logic signed [C_W-1:0] r_ca;
    logic                  r_neg;

    logic signed [D_W-1:0] diff;
    logic [D_W-1:0]        d_in;
    logic [H_W-1:0]        ma_in;
    logic signed [C_W:0]   dc;
    logic [C_W:0]          mdc_in;
    logic                  degen;
    logic                  last;
    logic [N_W-1:0]        n_acc;
    logic [D_W:0]          trial;
    logic                  ge;
    logic [D_W-1:0]        n_rem;
    logic [C_W-1:0]        n_nlo;
    logic signed [C_W+1:0] sum;

    // Operand magnitudes and the degenerate-edge test.
    always_comb begin
        diff   = {i_req.ha[H_W-1], i_req.ha} - {i_req.hb[H_W-1], i_req.hb};
        d_in   = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
        ma_in  = i_req.ha[H_W-1] ? H_W'(-i_req.ha) : H_W'(i_req.ha);
        degen  = (d_in == '0) || ({1'b0, ma_in} > d_in);
        dc     = {i_req.cb[C_W-1], i_req.cb} - {i_req.ca[C_W-1], i_req.ca};
        mdc_in = dc[C_W] ? (C_W+1)'(-dc) : (C_W+1)'(dc);
    end

    // One multiply step and one divide step.
    always_comb begin
        last  = (r_cnt == 5'(C_W - 1));
        n_acc = {r_acc[N_W-2:0], 1'b0} + (r_mdc[C_W-1] ? N_W'(r_ma) : '0);
        trial = {r_rem, r_nlo[C_W-1]};
        ge    = (trial >= {1'b0, r_d});
        n_rem = ge ? D_W'(trial - {1'b0, r_d}) : trial[D_W-1:0];
        n_nlo = {r_nlo[C_W-2:0], ge};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            X_IDLE:  if (i_req.start) n_state = degen ? X_DONE : X_MUL;
            X_MUL:   if (last) n_state = X_DIV;
            X_DIV:   if (last) n_state = X_DONE;
            X_DONE:  n_state = X_IDLE;
            default: n_state = X_IDLE;
        endcase
    end

    // Status and the saturated result.
    always_comb begin
        sum = r_neg ? ({{2{r_ca[C_W-1]}}, r_ca} - {2'b00, r_nlo})
                    : ({{2{r_ca[C_W-1]}}, r_ca} + {2'b00, r_nlo});
        o_rsp.busy = (r_state != X_IDLE);
        o_rsp.done = (r_state == X_DONE);
        if (sum > (C_W+2)'(signed'(33'sh0_7FFF_FFFF))) begin
            o_rsp.result = {1'b0, {(C_W-1){1'b1}}};
        end else if (sum < -(C_W+2)'(signed'(34'sh0_8000_0000))) begin
            o_rsp.result = {1'b1, {(C_W-1){1'b0}}};
        end else begin
            o_rsp.result = sum[C_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= X_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            X_IDLE: begin
                if (i_req.start) begin
                    r_d   <= d_in;
                    r_ma  <= ma_in;
                    r_mdc <= mdc_in[C_W-1:0];
                    r_ca  <= i_req.ca;
                    r_neg <= dc[C_W];
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_nlo <= '0;
                end
            end
            X_MUL: begin
                r_acc <= n_acc;
                r_mdc <= {r_mdc[C_W-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (last) begin
                    r_rem <= D_W'(n_acc[N_W-1:C_W]);
                    r_nlo <= n_acc[C_W-1:0];
                end
            end
            X_DIV: begin
                r_rem <= n_rem;
                r_nlo <= n_nlo;
                r_cnt <= r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/grid_cell_contour_segments_unit.sv =====
// Contour segments of one grid cell, top level: sequencer, level walk, segment buffering.
// Depends on gccs_pkg and the serial crossing unit gccs_xunit.
//
// One cell is taken at a time and the input is not ready until its last segment has moved
// to the output register. Only levels within the cell's height range are split into
// triangles. Every interpolated coordinate of a segment (a segment has none, two or four)
// runs through the one serial multiply-divide unit, 32 multiply steps and 32 divide steps.
// Segments come out in order of rising level, then triangle, and the cell's final segment
// carries the last flag; a cell with no segments produces no beat.
module grid_cell_contour_segments_unit #(
    parameter int MAX_LEVELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic signed [31:0] i_height_lo_lo,
    input  logic signed [31:0] i_height_hi_lo,
    input  logic signed [31:0] i_height_hi_hi,
    input  logic signed [31:0] i_height_lo_hi,
    input  logic signed [31:0] i_xcoord_first,
    input  logic signed [31:0] i_xcoord_second,
    input  logic signed [31:0] i_ycoord_first,
    input  logic signed [31:0] i_ycoord_second,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_level_index,
    output logic signed [31:0] o_start_x,
    output logic signed [31:0] o_start_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic        o_last_segment
);
    import gccs_pkg::*;

    localparam int K_W = $clog2(MAX_LEVELS + 1);

    // Configuration registers.
    logic signed [31:0]    r_base;
    logic [30:0]           r_step;
    logic [4:0]            r_count;

    // Sequencer and cell registers.
    t_state                r_state, n_state;
    logic signed [31:0]    r_v1, r_v2, r_v3, r_v4;
    logic signed [31:0]    r_x0, r_x1, r_y0, r_y1, r_xm, r_ym;
    logic signed [L_W-1:0] r_dmin, r_dmax, r_lev;
    logic [K_W-1:0]        r_k, r_cnt;
    logic signed [H_W-1:0] r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [1:0]            r_tri;
    t_route                r_route;
    logic [1:0]            r_j;
    logic signed [31:0]    r_cur [4];
    logic                  r_pend_v;
    logic [3:0]            r_pend_lvl;
    logic signed [31:0]    r_pend [4];
    logic                  r_out_v;
    logic [3:0]            r_out_lvl;
    logic signed [31:0]    r_out [4];
    logic                  r_out_last;

    t_ctl                  ctl;
    t_xreq                 xreq;
    t_xrsp                 xrsp;

    logic signed [31:0]    dmin, dmax, xm, ym;
    logic signed [32:0]    xsum, ysum, xadj, yadj;
    logic                  k_end, in_rng, out_free, seg_go;
    logic signed [L_W-1:0] dv1, dv2, dv3, dv4, dsum;
    logic signed [H_W-1:0] ha, hc;
    logic signed [31:0]    xa, ya, xc, yc;
    logic signed [31:0]    pa, pm, pc;
    t_case                 tri_code;
    t_src                  src;
    logic                  axis, is_edge;
    logic signed [31:0]    vert_val;

    gccs_xunit u_xunit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (xreq),
        .o_rsp   (xrsp)
    );

    // Cell range and centre position.
    always_comb begin
        dmin = r_v1;
        dmax = r_v1;
        if (r_v2 < dmin) dmin = r_v2;
        if (r_v2 > dmax) dmax = r_v2;
        if (r_v3 < dmin) dmin = r_v3;
        if (r_v3 > dmax) dmax = r_v3;
        if (r_v4 < dmin) dmin = r_v4;
        if (r_v4 > dmax) dmax = r_v4;
        xsum = {r_x0[31], r_x0} + {r_x1[31], r_x1};
        ysum = {r_y0[31], r_y0} + {r_y1[31], r_y1};
        xadj = xsum + {32'd0, xsum[32] & xsum[0]};
        yadj = ysum + {32'd0, ysum[32] & ysum[0]};
        xm   = xadj[32:1];
        ym   = yadj[32:1];
    end

    // Level tests and height differences against the current level.
    always_comb begin
        k_end  = (r_k == r_cnt);
        in_rng = (r_lev >= r_dmin) && (r_lev <= r_dmax);
        dv1    = {{(L_W-32){r_v1[31]}}, r_v1} - r_lev;
        dv2    = {{(L_W-32){r_v2[31]}}, r_v2} - r_lev;
        dv3    = {{(L_W-32){r_v3[31]}}, r_v3} - r_lev;
        dv4    = {{(L_W-32){r_v4[31]}}, r_v4} - r_lev;
        dsum   = dv1 + dv2 + dv3 + dv4;
    end

    // Outer corners of the current triangle: a is corner r_tri+1, c the next one around.
    always_comb begin
        unique case (r_tri)
            2'd0: begin
                ha = r_h1; xa = r_x0; ya = r_y0;
                hc = r_h2; xc = r_x1; yc = r_y0;
            end
            2'd1: begin
                ha = r_h2; xa = r_x1; ya = r_y0;
                hc = r_h3; xc = r_x1; yc = r_y1;
            end
            2'd2: begin
                ha = r_h3; xa = r_x1; ya = r_y1;
                hc = r_h4; xc = r_x0; yc = r_y1;
            end
            default: begin
                ha = r_h4; xa = r_x0; ya = r_y1;
                hc = r_h1; xc = r_x0; yc = r_y0;
            end
        endcase
        tri_code = case_code(sign_idx(ha), sign_idx(r_h0), sign_idx(hc));
    end

    // Source of the coordinate being built and the crossing request for it.
    always_comb begin
        src     = r_j[1] ? r_route.e : r_route.s;
        axis    = r_j[0];
        pa      = axis ? ya : xa;
        pm      = axis ? r_ym : r_xm;
        pc      = axis ? yc : xc;
        is_edge = (src == SRC_AB) || (src == SRC_BC) || (src == SRC_CA);
        unique case (src)
            SRC_A:   vert_val = pa;
            SRC_B:   vert_val = pm;
            SRC_C:   vert_val = pc;
            default: vert_val = pa;
        endcase
        xreq.start = ctl.x_start;
        unique case (src)
            SRC_BC: begin
                xreq.ha = r_h0; xreq.hb = hc; xreq.ca = pm; xreq.cb = pc;
            end
            SRC_CA: begin
                xreq.ha = hc; xreq.hb = ha; xreq.ca = pc; xreq.cb = pa;
            end
            default: begin
                xreq.ha = ha; xreq.hb = r_h0; xreq.ca = pa; xreq.cb = pm;
            end
        endcase
    end

    assign out_free = !r_out_v || i_out_ready;
    assign seg_go   = !r_pend_v || out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SETUP;
            S_SETUP: n_state = S_LEVEL;
            S_LEVEL: begin
                if (k_end) begin
                    n_state = S_FIN;
                end else if (in_rng) begin
                    n_state = S_HCALC;
                end
            end
            S_HCALC: n_state = S_TRI;
            S_TRI: begin
                if (tri_code != SEG_NONE) begin
                    n_state = S_COORD;
                end else if (r_tri == 2'd3) begin
                    n_state = S_LEVEL;
                end
            end
            S_COORD: begin
                if (is_edge) begin
                    n_state = S_WAIT;
                end else if (r_j == 2'd3) begin
                    n_state = S_SEG;
                end
            end
            S_WAIT: begin
                if (xrsp.done) n_state = (r_j == 2'd3) ? S_SEG : S_COORD;
            end
            S_SEG: begin
                if (seg_go) n_state = (r_tri == 2'd3) ? S_LEVEL : S_TRI;
            end
            S_FIN: begin
                if (!r_pend_v || out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath strobes.
    always_comb begin
        ctl = '0;
        unique case (r_state)
            S_IDLE:  ctl.load_item = i_in_valid;
            S_SETUP: ctl.setup = 1'b1;
            S_LEVEL: ctl.lvl_next = !k_end && !in_rng;
            S_HCALC: ctl.h_load = 1'b1;
            S_TRI: begin
                if (tri_code == SEG_NONE) begin
                    ctl.tri_next = 1'b1;
                    ctl.lvl_next = (r_tri == 2'd3);
                end else begin
                    ctl.route_load = 1'b1;
                end
            end
            S_COORD: begin
                if (is_edge) begin
                    ctl.x_start = 1'b1;
                end else begin
                    ctl.cur_vert = 1'b1;
                    ctl.j_next   = 1'b1;
                end
            end
            S_WAIT: begin
                ctl.cur_div = xrsp.done;
                ctl.j_next  = xrsp.done;
            end
            S_SEG: begin
                if (seg_go) begin
                    ctl.pend_load = 1'b1;
                    ctl.out_load  = r_pend_v;
                    ctl.tri_next  = 1'b1;
                    ctl.lvl_next  = (r_tri == 2'd3);
                end
            end
            S_FIN: begin
                if (r_pend_v && out_free) begin
                    ctl.out_load   = 1'b1;
                    ctl.out_last   = 1'b1;
                    ctl.pend_clear = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_base   <= '0;
            r_step   <= 31'd65536;
            r_count  <= 5'd1;
        end else begin
            r_state <= n_state;
            if (ctl.pend_load) begin
                r_pend_v <= 1'b1;
            end else if (ctl.pend_clear) begin
                r_pend_v <= 1'b0;
            end
            if (ctl.out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_STEP:  r_step  <= i_cfg_data[30:0];
                    CFG_COUNT: r_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // Cell, level and segment registers.
    always_ff @(posedge i_clk) begin
        if (ctl.load_item) begin
            r_v1 <= i_height_lo_lo;
            r_v2 <= i_height_hi_lo;
            r_v3 <= i_height_hi_hi;
            r_v4 <= i_height_lo_hi;
            r_x0 <= i_xcoord_first;
            r_x1 <= i_xcoord_second;
            r_y0 <= i_ycoord_first;
            r_y1 <= i_ycoord_second;
        end
        if (ctl.setup) begin
            r_dmin <= {{(L_W-32){dmin[31]}}, dmin};
            r_dmax <= {{(L_W-32){dmax[31]}}, dmax};
            r_xm   <= xm;
            r_ym   <= ym;
            r_lev  <= {{(L_W-32){r_base[31]}}, r_base};
            r_k    <= '0;
            if (32'(r_count) > MAX_LEVELS) begin
                r_cnt <= K_W'(MAX_LEVELS);
            end else begin
                r_cnt <= K_W'(r_count);
            end
        end
        if (ctl.lvl_next) begin
            r_k   <= r_k + K_W'(1);
            r_lev <= r_lev + L_W'(r_step);
        end
        if (ctl.h_load) begin
            r_h1  <= H_W'(dv1 <<< 2);
            r_h2  <= H_W'(dv2 <<< 2);
            r_h3  <= H_W'(dv3 <<< 2);
            r_h4  <= H_W'(dv4 <<< 2);
            r_h0  <= H_W'(dsum);
            r_tri <= 2'd0;
        end
        if (ctl.tri_next) begin
            r_tri <= r_tri + 2'd1;
        end
        if (ctl.route_load) begin
            r_route <= case_route(tri_code);
            r_j     <= 2'd0;
        end
        if (ctl.cur_vert) begin
            r_cur[r_j] <= vert_val;
        end else if (ctl.cur_div) begin
            r_cur[r_j] <= xrsp.result;
        end
        if (ctl.j_next) begin
            r_j <= r_j + 2'd1;
        end
        if (ctl.out_load) begin
            r_out_lvl  <= r_pend_lvl;
            r_out      <= r_pend;
            r_out_last <= ctl.out_last;
        end
        if (ctl.pend_load) begin
            r_pend_lvl <= 4'(r_k);
            r_pend     <= r_cur;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_v;
    assign o_level_index  = r_out_lvl;
    assign o_start_x      = r_out[0];
    assign o_start_y      = r_out[1];
    assign o_end_x        = r_out[2];
    assign o_end_y        = r_out[3];
    assign o_last_segment = r_out_last;

    // A crossing is only awaited while the unit is working on it.
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> xrsp.busy)
        else $error("waiting on an idle crossing unit");

    // A finished cell leaves no segment behind in the holding register.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_v)
        else $error("segment left pending at end of cell");

    // The level counter never runs past the clamped count.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_SETUP) |-> r_k <= r_cnt)
        else $error("level index past count");

    // A segment is only finished after its coordinates were built.
    a_seg_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SEG) |->
            ($past(r_state) == S_COORD || $past(r_state) == S_WAIT))
        else $error("segment entered without coordinate steps");

    // The last flag only goes out with the cell's final beat.
    a_last_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_last |=> (r_state == S_IDLE && o_last_segment && o_out_valid))
        else $error("last flag without end of cell");

endmodule
